// ----- rtl/pal_pkg.sv -----
// Shared types and constants for the positional array list unit.
// Depends on nothing; imported by pal_cell and positional_array_list_unit.
package pal_pkg;

   localparam int unsigned POS_WIDTH   = 6;
   localparam int unsigned DATA_WIDTH  = 32;
   localparam int unsigned FUNC_WIDTH  = 2;

   localparam logic [FUNC_WIDTH-1:0] FUNC_READ   = 2'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_INSERT = 2'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_DELETE = 2'd2;

   typedef struct packed {
      logic [FUNC_WIDTH-1:0]        func;
      logic [POS_WIDTH-1:0]         position;
      logic signed [DATA_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic                         ok;
      logic signed [DATA_WIDTH-1:0] value_out;
      logic [POS_WIDTH-1:0]         count;
   } rsp_type;

   // Broadcast to every cell of the chain in the cycle of a transfer.
   typedef struct packed {
      logic                  shift_up;
      logic                  shift_down;
      logic [POS_WIDTH-1:0]  index;
      logic [DATA_WIDTH-1:0] value;
   } cell_ctrl_type;

endpackage

// ----- rtl/pal_cell.sv -----
// One list slot of the shifting chain.
// Depends on pal_pkg.
module pal_cell #(
   parameter int unsigned INDEX = 0
) (
   input  logic                                clock,
   input  pal_pkg::cell_ctrl_type              ctrl,
   input  logic [pal_pkg::DATA_WIDTH-1:0]      left_entry,
   input  logic [pal_pkg::DATA_WIDTH-1:0]      right_entry,
   output logic [pal_pkg::DATA_WIDTH-1:0]      entry
);
   import pal_pkg::*;

   logic [DATA_WIDTH-1:0] entry_ff;
   logic [DATA_WIDTH-1:0] entry_in;
   logic [POS_WIDTH-1:0]  my_index;

   assign my_index = POS_WIDTH'(INDEX);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift_up) begin
         if (my_index == ctrl.index) begin
            entry_in = ctrl.value;
         end else if (my_index > ctrl.index) begin
            entry_in = left_entry;
         end
      end else if (ctrl.shift_down) begin
         // pull from the right neighbor at and above the removed slot
         if (my_index >= ctrl.index) begin
            entry_in = right_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ----- rtl/positional_array_list_unit.sv -----
// Positional array list unit: ordered list of CAPACITY 32-bit entries.
// The result is registered and valid in the cycle after the request transfer.
// Throughput: one transfer per cycle unless a held result stalls; all cells
// shift in parallel, and the single output register holds a result while the
// next request is taken. Reset clears the length and the result valid; entry
// contents stay unknown until written by an insert.
module positional_array_list_unit #(
   parameter int unsigned CAPACITY = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pal_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pal_pkg::rsp_type rsp_data
);
   import pal_pkg::*;

   // Chain wiring: entry_w[k] is the content of the k-th slot (zero-based).
   logic [DATA_WIDTH-1:0] entry_w [CAPACITY];
   cell_ctrl_type         ctrl;

   logic [POS_WIDTH-1:0]  length_ff;
   logic [POS_WIDTH-1:0]  length_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   logic                  accept;
   logic                  pos_nonzero;
   logic                  pos_in_list;
   logic                  pos_insertable;
   logic                  not_full;
   logic [POS_WIDTH-1:0]  pos_idx;
   logic [DATA_WIDTH-1:0] read_value;

   // Take a new request whenever the output register is empty or drains now.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign pos_idx        = req_data.position - POS_WIDTH'(1);
   assign pos_nonzero    = (req_data.position != '0);
   assign pos_in_list    = pos_nonzero && (req_data.position <= length_ff);
   assign pos_insertable = pos_nonzero &&
                           ({1'b0, req_data.position} <= ({1'b0, length_ff} + 7'd1));
   assign not_full       = (length_ff < POS_WIDTH'(CAPACITY));

   // Select the addressed slot for read and delete.
   always_comb begin
      read_value = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         if (pos_idx == POS_WIDTH'(k)) begin
            read_value = entry_w[k];
         end
      end
   end

   // Decode the request into chain control, the new length and the result.
   always_comb begin
      ctrl.shift_up   = 1'b0;
      ctrl.shift_down = 1'b0;
      ctrl.index      = pos_idx;
      ctrl.value      = req_data.value;
      length_in       = length_ff;
      rsp_in.ok        = 1'b0;
      rsp_in.value_out = '0;
      case (req_data.func)
         FUNC_READ: begin
            if (pos_in_list) begin
               rsp_in.ok        = 1'b1;
               rsp_in.value_out = read_value;
            end
         end
         FUNC_INSERT: begin
            if (not_full && pos_insertable) begin
               rsp_in.ok     = 1'b1;
               ctrl.shift_up = accept;
               length_in     = length_ff + POS_WIDTH'(1);
            end
         end
         FUNC_DELETE: begin
            if (pos_in_list) begin
               rsp_in.ok        = 1'b1;
               rsp_in.value_out = read_value;
               ctrl.shift_down  = accept;
               length_in        = length_ff - POS_WIDTH'(1);
            end
         end
         default: begin
            // unused selector: reject, leave the list untouched
         end
      endcase
      rsp_in.count = length_in;
   end

   // Hold the result until the transfer on the response side; load on accept.
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            length_ff <= length_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Row of cells; each shifts to or from its neighbors on insert and delete.
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w;
      logic [DATA_WIDTH-1:0] right_w;
      if (k == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_inner_left
         assign left_w = entry_w[k-1];
      end
      if (k == CAPACITY - 1) begin : g_last
         assign right_w = entry_w[k];
      end else begin : g_inner_right
         assign right_w = entry_w[k+1];
      end
      pal_cell #(
         .INDEX (k)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .left_entry  (left_w),
         .right_entry (right_w),
         .entry       (entry_w[k])
      );
   end

endmodule
